[sv/i2cmbe_pkg.sv]
package i2cmbe_pkg;

	// Command codes carried in the opcode field.
	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_STOP    = 3'd1;
	localparam logic [2:0] OP_RSTART  = 3'd2;
	localparam logic [2:0] OP_WRITE   = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;
	localparam logic [2:0] OP_RECOVER = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_LOW_TICKS  = 2'd0;
	localparam logic [1:0] REG_HIGH_TICKS = 2'd1;
	localparam logic [1:0] REG_HOLD_TICKS = 2'd2;
	localparam logic [1:0] REG_ACK_TICKS  = 2'd3;

	localparam logic [7:0] LOW_TICKS_RST  = 8'd11;
	localparam logic [7:0] HIGH_TICKS_RST = 8'd5;
	localparam logic [7:0] HOLD_TICKS_RST = 8'd20;
	localparam logic [7:0] ACK_TICKS_RST  = 8'd11;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_REC_LOW  = 5'd1,
		PH_REC_HIGH = 5'd2,
		PH_STOP_A   = 5'd3,
		PH_STOP_B   = 5'd4,
		PH_STOP_C   = 5'd5,
		PH_START_A  = 5'd6,
		PH_START_B  = 5'd7,
		PH_RS_A     = 5'd8,
		PH_RS_B     = 5'd9,
		PH_RS_C     = 5'd10,
		PH_WR_LOW   = 5'd11,
		PH_WR_HIGH  = 5'd12,
		PH_WA_LOW   = 5'd13,
		PH_WA_HIGH  = 5'd14,
		PH_RD_LOW   = 5'd15,
		PH_RD_HIGH  = 5'd16,
		PH_RA_LOW   = 5'd17,
		PH_RA_HIGH  = 5'd18
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_in_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       ack_received;
		logic [7:0] rx_byte;
	} tick_out_t;

endpackage

[sv/i2c_master_byte_engine_unit.sv]
// I2C master byte engine. Every request on the input channel is one bus timing tick: the
// sampled data line plus an optional command (start, stop, repeated start, write byte, read
// byte, bus recovery). Every request yields exactly one result request carrying the clock and
// data drive levels, busy, done, the last received ACK and the last read byte. A tick is taken
// in every clock cycle unless a result waits unread: the whole sequencer step is done
// between the state and result registers, so a tick's result appears on the next cycle. The
// result register decouples the two channels; input stalls only while a result waits unread.
// Phase lengths are in ticks and come from the four configuration registers (zero acts as one);
// write them only while the engine is idle.
module i2c_master_byte_engine_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  i2cmbe_pkg::tick_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output i2cmbe_pkg::tick_out_t out_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data
);

	logic [7:0] low_ticks_q, high_ticks_q, hold_ticks_q, ack_ticks_q;

	i2cmbe_pkg::phase_t phase_q, phase_d;
	logic [2:0] act_cmd_q, act_cmd_d;
	logic [2:0] bit_idx_q, bit_idx_d;
	logic [7:0] tick_q, tick_d;
	logic [7:0] shift_q, shift_d;
	logic       ack_flag_q, ack_flag_d;
	logic       ack_send_q, ack_send_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       ack_seen_q, ack_seen_d;
	logic [7:0] rx_hold_q, rx_hold_d;
	logic       done_d;

	logic                 enter_en;
	i2cmbe_pkg::phase_t   enter_ph;
	logic                 enter_c, enter_d;
	logic [7:0]           enter_len;
	logic                 fin_en, fin_c, fin_d;
	logic [7:0]           tick_dec;

	logic                  accept;
	logic                  out_valid_q;
	i2cmbe_pkg::tick_out_t out_q;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_ticks_q  <= i2cmbe_pkg::LOW_TICKS_RST;
			high_ticks_q <= i2cmbe_pkg::HIGH_TICKS_RST;
			hold_ticks_q <= i2cmbe_pkg::HOLD_TICKS_RST;
			ack_ticks_q  <= i2cmbe_pkg::ACK_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cmbe_pkg::REG_LOW_TICKS:  low_ticks_q  <= cfg_data;
				i2cmbe_pkg::REG_HIGH_TICKS: high_ticks_q <= cfg_data;
				i2cmbe_pkg::REG_HOLD_TICKS: hold_ticks_q <= cfg_data;
				i2cmbe_pkg::REG_ACK_TICKS:  ack_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state of the sequencer for the tick on the input.
	always_comb begin
		phase_d    = phase_q;
		act_cmd_d  = act_cmd_q;
		bit_idx_d  = bit_idx_q;
		shift_d    = shift_q;
		ack_flag_d = ack_flag_q;
		ack_send_d = ack_send_q;
		ack_seen_d = ack_seen_q;
		rx_hold_d  = rx_hold_q;
		done_d     = 1'b0;
		enter_en   = 1'b0;
		enter_ph   = i2cmbe_pkg::PH_IDLE;
		fin_en     = 1'b0;
		fin_c      = 1'b1;
		fin_d      = 1'b1;
		tick_dec   = (tick_q != 8'd0) ? tick_q - 8'd1 : 8'd0;
		tick_d     = tick_dec;

		if (phase_q == i2cmbe_pkg::PH_IDLE) begin
			tick_d = tick_q;
			if (in_data.cmd_valid &&
				(in_data.opcode inside {[i2cmbe_pkg::OP_START:i2cmbe_pkg::OP_RECOVER]})) begin
				act_cmd_d = in_data.opcode;
				enter_en  = 1'b1;
				case (in_data.opcode)
					i2cmbe_pkg::OP_START: begin
						enter_ph = in_data.sda_in ? i2cmbe_pkg::PH_START_A
							: i2cmbe_pkg::PH_REC_LOW;
					end
					i2cmbe_pkg::OP_STOP:   enter_ph = i2cmbe_pkg::PH_STOP_A;
					i2cmbe_pkg::OP_RSTART: enter_ph = i2cmbe_pkg::PH_RS_A;
					i2cmbe_pkg::OP_WRITE: begin
						shift_d    = in_data.tx_byte;
						bit_idx_d  = 3'd7;
						ack_seen_d = 1'b0;
						enter_ph   = i2cmbe_pkg::PH_WR_LOW;
					end
					i2cmbe_pkg::OP_READ: begin
						shift_d    = 8'd0;
						bit_idx_d  = 3'd7;
						ack_send_d = in_data.send_ack;
						enter_ph   = i2cmbe_pkg::PH_RD_LOW;
					end
					default: enter_ph = i2cmbe_pkg::PH_REC_LOW;
				endcase
			end
		end else begin
			if (phase_q == i2cmbe_pkg::PH_WA_HIGH && !in_data.sda_in) begin
				ack_seen_d = 1'b1;
			end
			// Read data is sampled on the last tick of the clock high window.
			if (phase_q == i2cmbe_pkg::PH_RD_HIGH && tick_q <= 8'd1 && in_data.sda_in) begin
				shift_d[bit_idx_q] = 1'b1;
			end
			if (tick_dec == 8'd0) begin
				enter_en = 1'b1;
				case (phase_q)
					i2cmbe_pkg::PH_REC_LOW: begin
						enter_ph = in_data.sda_in ? i2cmbe_pkg::PH_STOP_A
							: i2cmbe_pkg::PH_REC_HIGH;
					end
					i2cmbe_pkg::PH_REC_HIGH: enter_ph = i2cmbe_pkg::PH_REC_LOW;
					i2cmbe_pkg::PH_STOP_A:   enter_ph = i2cmbe_pkg::PH_STOP_B;
					i2cmbe_pkg::PH_STOP_B:   enter_ph = i2cmbe_pkg::PH_STOP_C;
					i2cmbe_pkg::PH_STOP_C: begin
						// A start that needed recovery continues into the start itself.
						if (act_cmd_q == i2cmbe_pkg::OP_START) begin
							enter_ph = i2cmbe_pkg::PH_START_A;
						end else begin
							enter_en = 1'b0;
							fin_en   = 1'b1;
						end
					end
					i2cmbe_pkg::PH_START_A: enter_ph = i2cmbe_pkg::PH_START_B;
					i2cmbe_pkg::PH_START_B: begin
						enter_en = 1'b0;
						fin_en   = 1'b1;
						fin_c    = 1'b0;
						fin_d    = 1'b0;
					end
					i2cmbe_pkg::PH_RS_A: enter_ph = i2cmbe_pkg::PH_RS_B;
					i2cmbe_pkg::PH_RS_B: enter_ph = i2cmbe_pkg::PH_RS_C;
					i2cmbe_pkg::PH_RS_C: begin
						enter_en = 1'b0;
						fin_en   = 1'b1;
						fin_d    = 1'b0;
					end
					i2cmbe_pkg::PH_WR_LOW: enter_ph = i2cmbe_pkg::PH_WR_HIGH;
					i2cmbe_pkg::PH_WR_HIGH: begin
						if (bit_idx_q == 3'd0) begin
							enter_ph = i2cmbe_pkg::PH_WA_LOW;
						end else begin
							bit_idx_d = bit_idx_q - 3'd1;
							enter_ph  = i2cmbe_pkg::PH_WR_LOW;
						end
					end
					i2cmbe_pkg::PH_WA_LOW: enter_ph = i2cmbe_pkg::PH_WA_HIGH;
					i2cmbe_pkg::PH_WA_HIGH: begin
						enter_en   = 1'b0;
						fin_en     = 1'b1;
						fin_c      = 1'b0;
						ack_flag_d = ack_seen_d;
					end
					i2cmbe_pkg::PH_RD_LOW: enter_ph = i2cmbe_pkg::PH_RD_HIGH;
					i2cmbe_pkg::PH_RD_HIGH: begin
						if (bit_idx_q == 3'd0) begin
							enter_ph = i2cmbe_pkg::PH_RA_LOW;
						end else begin
							bit_idx_d = bit_idx_q - 3'd1;
							enter_ph  = i2cmbe_pkg::PH_RD_LOW;
						end
					end
					i2cmbe_pkg::PH_RA_LOW: enter_ph = i2cmbe_pkg::PH_RA_HIGH;
					i2cmbe_pkg::PH_RA_HIGH: begin
						enter_en  = 1'b0;
						fin_en    = 1'b1;
						fin_c     = 1'b0;
						rx_hold_d = shift_d;
					end
					default: begin
						enter_en = 1'b0;
						fin_en   = 1'b1;
					end
				endcase
			end
		end

		scl_d = scl_q;
		sda_d = sda_q;
		if (enter_en) begin
			phase_d = enter_ph;
			scl_d   = enter_c;
			sda_d   = enter_d;
			tick_d  = enter_len;
		end
		if (fin_en) begin
			phase_d = i2cmbe_pkg::PH_IDLE;
			scl_d   = fin_c;
			sda_d   = fin_d;
			tick_d  = 8'd0;
			done_d  = 1'b1;
		end
	end

	// Line levels and length of the phase being entered.
	always_comb begin
		logic [7:0] len;
		len     = low_ticks_q;
		enter_c = 1'b1;
		enter_d = 1'b1;
		case (enter_ph)
			i2cmbe_pkg::PH_REC_LOW:  begin enter_c = 1'b0; len = low_ticks_q; end
			i2cmbe_pkg::PH_REC_HIGH: len = high_ticks_q;
			i2cmbe_pkg::PH_STOP_A:   begin enter_c = 1'b0; enter_d = 1'b0; end
			i2cmbe_pkg::PH_STOP_B:   begin enter_d = 1'b0; len = hold_ticks_q; end
			i2cmbe_pkg::PH_STOP_C:   len = high_ticks_q;
			i2cmbe_pkg::PH_START_A:  begin enter_d = 1'b0; len = hold_ticks_q; end
			i2cmbe_pkg::PH_START_B:  begin enter_c = 1'b0; enter_d = 1'b0; end
			i2cmbe_pkg::PH_RS_A:     enter_c = 1'b0;
			i2cmbe_pkg::PH_RS_B:     len = hold_ticks_q;
			i2cmbe_pkg::PH_RS_C:     begin enter_d = 1'b0; len = high_ticks_q; end
			i2cmbe_pkg::PH_WR_LOW:   begin enter_c = 1'b0; enter_d = shift_d[bit_idx_d]; end
			i2cmbe_pkg::PH_WR_HIGH: begin
				enter_d = shift_d[bit_idx_d];
				len     = high_ticks_q;
			end
			i2cmbe_pkg::PH_WA_LOW:   enter_c = 1'b0;
			i2cmbe_pkg::PH_WA_HIGH:  len = ack_ticks_q;
			i2cmbe_pkg::PH_RD_LOW:   enter_c = 1'b0;
			i2cmbe_pkg::PH_RD_HIGH:  len = high_ticks_q;
			i2cmbe_pkg::PH_RA_LOW:   begin enter_c = 1'b0; enter_d = !ack_send_d; end
			i2cmbe_pkg::PH_RA_HIGH: begin
				enter_d = !ack_send_d;
				len     = ack_ticks_q;
			end
			default: ;
		endcase
		enter_len = (len == 8'd0) ? 8'd1 : len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= i2cmbe_pkg::PH_IDLE;
			act_cmd_q  <= 3'd0;
			bit_idx_q  <= 3'd0;
			tick_q     <= 8'd0;
			shift_q    <= 8'd0;
			ack_flag_q <= 1'b0;
			ack_send_q <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_seen_q <= 1'b0;
			rx_hold_q  <= 8'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			act_cmd_q  <= act_cmd_d;
			bit_idx_q  <= bit_idx_d;
			tick_q     <= tick_d;
			shift_q    <= shift_d;
			ack_flag_q <= ack_flag_d;
			ack_send_q <= ack_send_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			ack_seen_q <= ack_seen_d;
			rx_hold_q  <= rx_hold_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.scl_out      <= scl_d;
			out_q.sda_out      <= sda_d;
			out_q.busy_res     <= (phase_d != i2cmbe_pkg::PH_IDLE);
			out_q.done_res     <= done_d;
			out_q.ack_received <= ack_flag_d;
			out_q.rx_byte      <= rx_hold_d;
		end
	end

	// A running phase always has ticks left; idle holds a zero count.
	a_tick_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2cmbe_pkg::PH_IDLE) == (tick_q == 8'd0))
		else $error("tick count disagrees with phase");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && done_d |=> out_valid_q && !out_q.busy_res)
		else $error("completion reported while still busy");

	a_ack_window_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2cmbe_pkg::PH_WA_HIGH || phase_q == i2cmbe_pkg::PH_RD_HIGH) |-> scl_q)
		else $error("clock not released in a sampling window");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q && out_q.scl_out == $past(scl_d))
		else $error("result register missed an accepted tick");

endmodule

[bench/tb_i2c_master_byte_engine_unit.sv]
module tb_i2c_master_byte_engine_unit;

	// Opcodes the block must drop without starting anything.
	localparam logic [2:0] OP_RSVD_LO = 3'd6;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;

	// How the sampled data line behaves on the ticks that follow a command.
	localparam int LINE_RANDOM = 0;
	localparam int LINE_HIGH   = 1;
	localparam int LINE_LOW    = 2;

	localparam int QUIET_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	i2cmbe_pkg::tick_in_t  in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	i2cmbe_pkg::tick_out_t out_data;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_index = i2cmbe_pkg::REG_LOW_TICKS;
	logic [7:0]            cfg_data = '0;

	i2cmbe_pkg::tick_in_t  tick_q[$];
	i2cmbe_pkg::tick_out_t levels_q[$];
	int        fed = 0;
	int        mismatches = 0;
	int        send_gap = 0;
	int        rx_stall = 0;
	int        quiet = 0;
	bit        steady = 1'b0;

	// Shadow of the sequencer: timing registers and bus state.
	logic [7:0]         low_cfg = i2cmbe_pkg::LOW_TICKS_RST;
	logic [7:0]         high_cfg = i2cmbe_pkg::HIGH_TICKS_RST;
	logic [7:0]         hold_cfg = i2cmbe_pkg::HOLD_TICKS_RST;
	logic [7:0]         ack_cfg = i2cmbe_pkg::ACK_TICKS_RST;
	i2cmbe_pkg::phase_t ph = i2cmbe_pkg::PH_IDLE;
	logic [2:0]         cur_op = i2cmbe_pkg::OP_START;
	logic [2:0]         bit_pos = '0;
	logic [7:0]         ticks_left = '0;
	logic [7:0]         shreg = '0;
	logic [7:0]         rx_last = '0;
	logic               ack_last = 1'b0;
	logic               ack_drive = 1'b0;
	logic               ack_hit = 1'b0;
	logic               scl_drv = 1'b1;
	logic               sda_drv = 1'b1;

	i2c_master_byte_engine_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int nz(input logic [7:0] v);
		return (v == 8'd0) ? 1 : int'(v);
	endfunction

	function automatic int pace();
		return steady ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic enter_phase(input i2cmbe_pkg::phase_t p);
		logic       c;
		logic       d;
		logic [7:0] t;
		c = 1'b1;
		d = 1'b1;
		t = low_cfg;
		case (p)
			i2cmbe_pkg::PH_REC_LOW:  begin c = 1'b0; t = low_cfg; end
			i2cmbe_pkg::PH_REC_HIGH: begin t = high_cfg; end
			i2cmbe_pkg::PH_STOP_A:   begin c = 1'b0; d = 1'b0; t = low_cfg; end
			i2cmbe_pkg::PH_STOP_B:   begin d = 1'b0; t = hold_cfg; end
			i2cmbe_pkg::PH_STOP_C:   begin t = high_cfg; end
			i2cmbe_pkg::PH_START_A:  begin d = 1'b0; t = hold_cfg; end
			i2cmbe_pkg::PH_START_B:  begin c = 1'b0; d = 1'b0; t = low_cfg; end
			i2cmbe_pkg::PH_RS_A:     begin c = 1'b0; t = low_cfg; end
			i2cmbe_pkg::PH_RS_B:     begin t = hold_cfg; end
			i2cmbe_pkg::PH_RS_C:     begin d = 1'b0; t = high_cfg; end
			i2cmbe_pkg::PH_WR_LOW:   begin c = 1'b0; d = shreg[bit_pos]; t = low_cfg; end
			i2cmbe_pkg::PH_WR_HIGH:  begin d = shreg[bit_pos]; t = high_cfg; end
			i2cmbe_pkg::PH_WA_LOW:   begin c = 1'b0; t = low_cfg; end
			i2cmbe_pkg::PH_WA_HIGH:  begin t = ack_cfg; end
			i2cmbe_pkg::PH_RD_LOW:   begin c = 1'b0; t = low_cfg; end
			i2cmbe_pkg::PH_RD_HIGH:  begin t = high_cfg; end
			i2cmbe_pkg::PH_RA_LOW:   begin c = 1'b0; d = ~ack_drive; t = low_cfg; end
			i2cmbe_pkg::PH_RA_HIGH:  begin d = ~ack_drive; t = ack_cfg; end
			default: ;
		endcase
		ph = p;
		scl_drv = c;
		sda_drv = d;
		ticks_left = (t == 8'd0) ? 8'd1 : t;
	endtask

	task automatic close_cmd(input logic c, input logic d);
		ph = i2cmbe_pkg::PH_IDLE;
		scl_drv = c;
		sda_drv = d;
		ticks_left = 8'd0;
	endtask

	// Move on once the current phase has used up its ticks.
	task automatic advance_phase(input logic sda, output logic done);
		done = 1'b0;
		case (ph)
			i2cmbe_pkg::PH_REC_LOW:
				enter_phase(sda ? i2cmbe_pkg::PH_STOP_A : i2cmbe_pkg::PH_REC_HIGH);
			i2cmbe_pkg::PH_REC_HIGH: enter_phase(i2cmbe_pkg::PH_REC_LOW);
			i2cmbe_pkg::PH_STOP_A:   enter_phase(i2cmbe_pkg::PH_STOP_B);
			i2cmbe_pkg::PH_STOP_B:   enter_phase(i2cmbe_pkg::PH_STOP_C);
			i2cmbe_pkg::PH_STOP_C: begin
				if (cur_op == i2cmbe_pkg::OP_START) begin
					enter_phase(i2cmbe_pkg::PH_START_A);
				end else begin
					close_cmd(1'b1, 1'b1);
					done = 1'b1;
				end
			end
			i2cmbe_pkg::PH_START_A:  enter_phase(i2cmbe_pkg::PH_START_B);
			i2cmbe_pkg::PH_START_B: begin
				close_cmd(1'b0, 1'b0);
				done = 1'b1;
			end
			i2cmbe_pkg::PH_RS_A:     enter_phase(i2cmbe_pkg::PH_RS_B);
			i2cmbe_pkg::PH_RS_B:     enter_phase(i2cmbe_pkg::PH_RS_C);
			i2cmbe_pkg::PH_RS_C: begin
				close_cmd(1'b1, 1'b0);
				done = 1'b1;
			end
			i2cmbe_pkg::PH_WR_LOW:   enter_phase(i2cmbe_pkg::PH_WR_HIGH);
			i2cmbe_pkg::PH_WR_HIGH: begin
				if (bit_pos == 3'd0) begin
					enter_phase(i2cmbe_pkg::PH_WA_LOW);
				end else begin
					bit_pos = bit_pos - 3'd1;
					enter_phase(i2cmbe_pkg::PH_WR_LOW);
				end
			end
			i2cmbe_pkg::PH_WA_LOW:   enter_phase(i2cmbe_pkg::PH_WA_HIGH);
			i2cmbe_pkg::PH_WA_HIGH: begin
				ack_last = ack_hit;
				close_cmd(1'b0, 1'b1);
				done = 1'b1;
			end
			i2cmbe_pkg::PH_RD_LOW:   enter_phase(i2cmbe_pkg::PH_RD_HIGH);
			i2cmbe_pkg::PH_RD_HIGH: begin
				if (bit_pos == 3'd0) begin
					enter_phase(i2cmbe_pkg::PH_RA_LOW);
				end else begin
					bit_pos = bit_pos - 3'd1;
					enter_phase(i2cmbe_pkg::PH_RD_LOW);
				end
			end
			i2cmbe_pkg::PH_RA_LOW:   enter_phase(i2cmbe_pkg::PH_RA_HIGH);
			i2cmbe_pkg::PH_RA_HIGH: begin
				rx_last = shreg;
				close_cmd(1'b0, 1'b1);
				done = 1'b1;
			end
			default: begin
				close_cmd(1'b1, 1'b1);
				done = 1'b1;
			end
		endcase
	endtask

	// One bus tick of the sequencer: returns the line levels and status it shows.
	task automatic sequencer_tick(input i2cmbe_pkg::tick_in_t t,
			output i2cmbe_pkg::tick_out_t r);
		logic done;
		done = 1'b0;
		if (ph == i2cmbe_pkg::PH_IDLE) begin
			if (t.cmd_valid && t.opcode <= i2cmbe_pkg::OP_RECOVER) begin
				cur_op = t.opcode;
				case (t.opcode)
					i2cmbe_pkg::OP_START:
						enter_phase(t.sda_in ? i2cmbe_pkg::PH_START_A
							: i2cmbe_pkg::PH_REC_LOW);
					i2cmbe_pkg::OP_STOP:   enter_phase(i2cmbe_pkg::PH_STOP_A);
					i2cmbe_pkg::OP_RSTART: enter_phase(i2cmbe_pkg::PH_RS_A);
					i2cmbe_pkg::OP_WRITE: begin
						shreg = t.tx_byte;
						bit_pos = 3'd7;
						ack_hit = 1'b0;
						enter_phase(i2cmbe_pkg::PH_WR_LOW);
					end
					i2cmbe_pkg::OP_READ: begin
						shreg = 8'd0;
						bit_pos = 3'd7;
						ack_drive = t.send_ack;
						enter_phase(i2cmbe_pkg::PH_RD_LOW);
					end
					default:   enter_phase(i2cmbe_pkg::PH_REC_LOW);
				endcase
			end
		end else begin
			if (ph == i2cmbe_pkg::PH_WA_HIGH && !t.sda_in)
				ack_hit = 1'b1;
			// Read bits are taken on the last tick of the clock high window.
			if (ph == i2cmbe_pkg::PH_RD_HIGH && ticks_left <= 8'd1 && t.sda_in)
				shreg[bit_pos] = 1'b1;
			if (ticks_left != 8'd0)
				ticks_left = ticks_left - 8'd1;
			if (ticks_left == 8'd0)
				advance_phase(t.sda_in, done);
		end
		r.scl_out = scl_drv;
		r.sda_out = sda_drv;
		r.busy_res = (ph != i2cmbe_pkg::PH_IDLE);
		r.done_res = done;
		r.ack_received = ack_last;
		r.rx_byte = rx_last;
	endtask

	function automatic int command_span(input logic [2:0] op);
		case (op)
			i2cmbe_pkg::OP_START:  return nz(hold_cfg) + nz(low_cfg);
			i2cmbe_pkg::OP_STOP,
			i2cmbe_pkg::OP_RSTART: return nz(low_cfg) + nz(hold_cfg) + nz(high_cfg);
			i2cmbe_pkg::OP_WRITE,
			i2cmbe_pkg::OP_READ:
				return 8 * (nz(low_cfg) + nz(high_cfg)) + nz(low_cfg) + nz(ack_cfg);
			default:   return 0;
		endcase
	endfunction

	function automatic i2cmbe_pkg::tick_in_t filler(input int mode);
		i2cmbe_pkg::tick_in_t t;
		t.cmd_valid = 1'b0;
		t.opcode = 3'($urandom_range(0, 7));
		t.tx_byte = 8'($urandom_range(0, 255));
		t.send_ack = 1'($urandom_range(0, 1));
		case (mode)
			LINE_HIGH: t.sda_in = 1'b1;
			LINE_LOW:  t.sda_in = 1'b0;
			default:   t.sda_in = 1'($urandom_range(0, 1));
		endcase
		return t;
	endfunction

	task automatic feed(input i2cmbe_pkg::tick_in_t t);
		tick_q.push_back(t);
		fed++;
	endtask

	// Queue a command request followed by enough ticks for it to finish. A noisy
	// command offers stray commands while busy; a cut one leaves too few ticks, so
	// the next command arrives while the engine is still at work.
	task automatic issue(input logic [2:0] op, input logic [7:0] tx, input logic sack,
			input int sda_mode, input bit noisy, input bit cut);
		i2cmbe_pkg::tick_in_t t;
		int       span;
		bit       rescue;
		rescue = (op == i2cmbe_pkg::OP_RECOVER)
			|| (op == i2cmbe_pkg::OP_START && sda_mode == LINE_LOW);
		t = filler(sda_mode);
		t.cmd_valid = 1'b1;
		t.opcode = op;
		t.tx_byte = tx;
		t.send_ack = sack;
		if (op == i2cmbe_pkg::OP_START)
			t.sda_in = !rescue;
		feed(t);
		if (rescue) begin
			// The slave holds data low for a while, then lets go.
			repeat ($urandom_range(0, 2 * (nz(low_cfg) + nz(high_cfg))))
				feed(filler(LINE_LOW));
			span = 3 * (nz(low_cfg) + nz(high_cfg)) + 2 * nz(hold_cfg) + nz(low_cfg);
			repeat (span)
				feed(filler(LINE_HIGH));
		end else begin
			span = command_span(op);
			if (cut && span > 0)
				span = $urandom_range(0, span - 1);
			repeat (span) begin
				t = filler(sda_mode);
				if (noisy && $urandom_range(0, 7) == 0)
					t.cmd_valid = 1'b1;
				feed(t);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			i2cmbe_pkg::REG_LOW_TICKS:  low_cfg = val;
			i2cmbe_pkg::REG_HIGH_TICKS: high_cfg = val;
			i2cmbe_pkg::REG_HOLD_TICKS: hold_cfg = val;
			i2cmbe_pkg::REG_ACK_TICKS:  ack_cfg = val;
			default: ;
		endcase
	endtask

	task automatic program_timing(input logic [7:0] l, input logic [7:0] h,
			input logic [7:0] d, input logic [7:0] a);
		write_reg(i2cmbe_pkg::REG_LOW_TICKS, l);
		write_reg(i2cmbe_pkg::REG_HIGH_TICKS, h);
		write_reg(i2cmbe_pkg::REG_HOLD_TICKS, d);
		write_reg(i2cmbe_pkg::REG_ACK_TICKS, a);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain every request and result, and leave the engine idle.
	task automatic settle();
		do begin
			while (tick_q.size() != 0 || in_valid || levels_q.size() != 0)
				@(posedge clk);
			if (ph != i2cmbe_pkg::PH_IDLE)
				repeat (16) feed(filler(LINE_HIGH));
		end while (ph != i2cmbe_pkg::PH_IDLE);
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed transactions with random content, plus stray commands.
	task automatic wander(input int count);
		int         goal;
		bit         noisy;
		bit         broken;
		logic [2:0] op;
		goal = fed + count;
		while (fed < goal) begin
			steady = ($urandom_range(0, 3) == 0);
			noisy = ($urandom_range(0, 4) == 0);
			broken = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 9) == 0) begin
				op = 3'($urandom_range(0, 7));
				issue(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					LINE_RANDOM, noisy, broken);
			end else begin
				issue(i2cmbe_pkg::OP_START, 8'h00, 1'b0,
					($urandom_range(0, 7) == 0) ? LINE_LOW : LINE_HIGH, noisy, 1'b0);
				issue(i2cmbe_pkg::OP_WRITE, 8'($urandom_range(0, 255)), 1'b0,
					LINE_RANDOM, noisy, 1'b0);
				repeat ($urandom_range(0, 3)) begin
					if ($urandom_range(0, 3) == 0)
						issue(i2cmbe_pkg::OP_RSTART, 8'h00, 1'b0, LINE_RANDOM, noisy, 1'b0);
					op = $urandom_range(0, 1) ? i2cmbe_pkg::OP_WRITE : i2cmbe_pkg::OP_READ;
					issue(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						LINE_RANDOM, noisy, broken && $urandom_range(0, 3) == 0);
				end
				issue(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, LINE_RANDOM, noisy, 1'b0);
			end
			repeat ($urandom_range(0, 3))
				feed(filler(LINE_RANDOM));
		end
	endtask

	always @(posedge clk) begin : driver
		i2cmbe_pkg::tick_out_t lv;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sequencer_tick(in_data, lv);
				levels_q.push_back(lv);
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					in_data <= tick_q.pop_front();
					in_valid <= 1'b1;
					send_gap <= pace();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : monitor
		i2cmbe_pkg::tick_out_t want;
		int        n;
		if (arst_n) begin
			n = (rx_stall != 0) ? rx_stall - 1 : 0;
			if (out_valid && out_ready) begin
				if (levels_q.size() == 0) begin
					$display("%0t: result with none pending, expected none, actual %h",
						$time, out_data);
					mismatches++;
				end else begin
					want = levels_q.pop_front();
					check_field("scl_out", 8'(want.scl_out), 8'(out_data.scl_out));
					check_field("sda_out", 8'(want.sda_out), 8'(out_data.sda_out));
					check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
					check_field("ack_received", 8'(want.ack_received),
						8'(out_data.ack_received));
					check_field("rx_byte", want.rx_byte, out_data.rx_byte);
				end
				n = pace();
			end
			rx_stall <= n;
			out_ready <= (n == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset timing first.
		issue(i2cmbe_pkg::OP_START, 8'h00, 1'b0, LINE_HIGH, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		settle();

		program_timing(8'd1, 8'd1, 8'd1, 8'd1);
		// Undefined opcodes are dropped without a done pulse.
		issue(OP_RSVD_LO, 8'h00, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		issue(OP_RSVD_HI, 8'hFF, 1'b1, LINE_RANDOM, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_START, 8'h00, 1'b0, LINE_HIGH, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b0, LINE_LOW, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_WRITE, 8'h00, 1'b1, LINE_HIGH, 1'b1, 1'b0);
		issue(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, LINE_HIGH, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_READ, 8'hFF, 1'b0, LINE_LOW, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_RSTART, 8'h00, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_WRITE, 8'hA5, 1'b0, LINE_RANDOM, 1'b0, 1'b1);
		issue(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		// A start with the data line held low recovers the bus first.
		issue(i2cmbe_pkg::OP_START, 8'h00, 1'b0, LINE_LOW, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_RECOVER, 8'h00, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		issue(i2cmbe_pkg::OP_READ, 8'h5A, 1'b1, LINE_RANDOM, 1'b0, 1'b0);
		wander(100);

		// Zero in a timing register acts as one.
		settle();
		program_timing(8'd0, 8'd2, 8'd0, 8'd3);
		wander(100);

		repeat (3) begin
			settle();
			program_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
				8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
			wander(100);
		end

		// Longest low and acknowledge settings on short commands.
		steady = 1'b0;
		settle();
		program_timing(8'd255, 8'd1, 8'd1, 8'd1);
		issue(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		settle();
		program_timing(8'd1, 8'd1, 8'd1, 8'd255);
		issue(i2cmbe_pkg::OP_WRITE, 8'h3C, 1'b0, LINE_RANDOM, 1'b0, 1'b0);
		settle();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && levels_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[i2c_master_byte_engine_unit.f]
sv/i2cmbe_pkg.sv
sv/i2c_master_byte_engine_unit.sv
bench/tb_i2c_master_byte_engine_unit.sv
